// ----- rtl/particle_voxel_density_histogram_core_assert.svh -----
// ----------------------------------------------------------------------------
// particle voxel density histogram assertion macros
// concurrent checks, left out of synthesis builds
// ----------------------------------------------------------------------------
`ifndef PARTICLE_VOXEL_DENSITY_HISTOGRAM_CORE_ASSERT_SVH
`define PARTICLE_VOXEL_DENSITY_HISTOGRAM_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define PVDH_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition must never be seen at a clock edge outside reset
`define PVDH_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define PVDH_ASSERT(lbl, clk, rst_n, prop, msg)
`define PVDH_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

// ----- rtl/pvdh_pkg.sv -----
// ----------------------------------------------------------------------------
// pvdh_pkg
// shared constants, codes and state type of the voxel density histogram
// ----------------------------------------------------------------------------
package pvdh_pkg;

  localparam int unsigned DimLimit  = 32;
  localparam int unsigned DimBits   = $clog2(DimLimit);
  localparam int unsigned CellBits  = 3 * DimBits;
  localparam int unsigned CellTotal = DimLimit * DimLimit * DimLimit;
  localparam int unsigned FixW      = 32;
  localparam int unsigned CountW    = 32;
  localparam int unsigned SizeW     = 6;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 32;

  typedef enum logic [1:0] {
    ACT_ADD   = 2'd0,
    ACT_READ  = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NOP   = 2'd3
  } action_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ORIGIN_X = 3'd0,
    CFG_ORIGIN_Y = 3'd1,
    CFG_ORIGIN_Z = 3'd2,
    CFG_INV_CELL = 3'd3,
    CFG_SIZE_X   = 3'd4,
    CFG_SIZE_Y   = 3'd5,
    CFG_SIZE_Z   = 3'd6
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_CHK,
    ST_LIN1,
    ST_LIN2,
    ST_RD1,
    ST_RD2,
    ST_FETCH,
    ST_UPDATE,
    ST_REPLY,
    ST_CLEAR
  } state_e;

endpackage

// ----- rtl/pvdh_item_if.sv -----
// ----------------------------------------------------------------------------
// pvdh_item_if
// request channel: action, particle position and read index
// ----------------------------------------------------------------------------
interface pvdh_item_if;
  import pvdh_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [1:0]                 action;
  logic signed [FixW-1:0]     pos_x;
  logic signed [FixW-1:0]     pos_y;
  logic signed [FixW-1:0]     pos_z;
  logic [CellBits-1:0]        read_index;

  modport source (
    output valid, action, pos_x, pos_y, pos_z, read_index,
    input  ready
  );

  modport sink (
    input  valid, action, pos_x, pos_y, pos_z, read_index,
    output ready
  );
endinterface

// ----- rtl/pvdh_result_if.sv -----
// ----------------------------------------------------------------------------
// pvdh_result_if
// result channel: cell count, hit flag and cell index
// ----------------------------------------------------------------------------
interface pvdh_result_if;
  import pvdh_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CountW-1:0]     cell_count;
  logic                  hit;
  logic [CellBits-1:0]   cell_index;

  modport source (
    output valid, cell_count, hit, cell_index,
    input  ready
  );

  modport sink (
    input  valid, cell_count, hit, cell_index,
    output ready
  );
endinterface

// ----- rtl/particle_voxel_density_histogram_core.sv -----
// sequence: an add multiplies and checks each axis in turn (a miss replies at the
//   failing axis), then linearizes, fetches and updates; a read sizes the grid and
//   checks the index (an invalid one replies), then fetches; clear writes one store
//   entry per cycle; an unused action replies; one request at a time, the shared
//   32x32 multiplier serving the axes in turn; reset: config returns to its defaults
//   and a sweep zeroes the count store, with item_i.ready low until it is done
// ----------------------------------------------------------------------------
// particle_voxel_density_histogram_core
// nearest grid point binning of fixed point particles into a voxel count grid
// ----------------------------------------------------------------------------
`include "particle_voxel_density_histogram_core_assert.svh"

module particle_voxel_density_histogram_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pvdh_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [pvdh_pkg::CfgDataW-1:0] cfg_data_i,
  pvdh_item_if.sink                     item_i,
  pvdh_result_if.source                 result_o
);
  import pvdh_pkg::*;

  localparam logic [1:0]          AxisLast = 2'd2;
  localparam logic [CellBits-1:0] ClrLast  = CellBits'(CellTotal - 1);

  // configuration registers
  logic [FixW-1:0]  org_x_q, org_y_q, org_z_q;
  logic [FixW-1:0]  inv_q;
  logic [SizeW-1:0] size_x_q, size_y_q, size_z_q;

  // sequencer and datapath registers
  state_e                 state_q, state_d;
  logic [1:0]             axis_q, axis_d;
  logic                   is_add_q, is_add_d;
  logic                   reply_q, reply_d;
  logic signed [FixW:0]   diff_q [3];
  logic signed [FixW:0]   diff_d [3];
  logic [CellBits-1:0]    rd_idx_q, rd_idx_d;
  logic [2*FixW-1:0]      prod_q, prod_d;
  logic [DimBits-1:0]     cell_q [3];
  logic [DimBits-1:0]     cell_d [3];
  logic [2*DimBits:0]     part_q, part_d;
  logic [CellBits-1:0]    addr_q, addr_d;
  logic [CellBits-1:0]    clr_cnt_q, clr_cnt_d;

  // output register
  logic                   out_valid_q, out_valid_d;
  logic [CountW-1:0]      out_count_q, out_count_d;
  logic                   out_hit_q, out_hit_d;
  logic [CellBits-1:0]    out_idx_q, out_idx_d;

  // count store
  logic [CountW-1:0]      mem [CellTotal];
  logic [CountW-1:0]      rdata_q;
  logic                   mem_we;
  logic [CellBits-1:0]    mem_waddr;
  logic [CountW-1:0]      mem_wdata;

  // combinational helpers
  logic                   item_fire;
  logic                   out_free;
  logic [SizeW-1:0]       size_eff [3];
  logic [SizeW-1:0]       size_cur;
  logic signed [FixW:0]   diff_cur;
  logic [FixW-1:0]        mul_a;
  logic [FixW-1:0]        coord_hi;
  logic                   axis_hit;
  logic [CellBits:0]      cell_total;
  logic                   read_ok;
  logic [CountW-1:0]      count_inc;

  assign item_fire = item_i.valid && item_i.ready;
  assign out_free  = !out_valid_q || result_o.ready;

  assign item_i.ready        = (state_q == ST_IDLE);
  assign result_o.valid      = out_valid_q;
  assign result_o.cell_count = out_count_q;
  assign result_o.hit        = out_hit_q;
  assign result_o.cell_index = out_idx_q;

  // sizes above the grid limit saturate to it
  assign size_eff[0] = (size_x_q > SizeW'(DimLimit)) ? SizeW'(DimLimit) : size_x_q;
  assign size_eff[1] = (size_y_q > SizeW'(DimLimit)) ? SizeW'(DimLimit) : size_y_q;
  assign size_eff[2] = (size_z_q > SizeW'(DimLimit)) ? SizeW'(DimLimit) : size_z_q;

  // shared multiplier operand: magnitude of a non-negative offset
  assign diff_cur = diff_q[axis_q];
  assign size_cur = size_eff[axis_q];
  assign mul_a    = diff_cur[FixW-1:0];
  assign coord_hi = prod_q[2*FixW-1:FixW];

  // a negative offset only lands in cell 0 when the scale is zero,
  // otherwise the floored coordinate must sit below the axis size
  assign axis_hit = diff_cur[FixW] ? ((inv_q == '0) && (size_cur != '0))
                                   : (coord_hi < {{(FixW-SizeW){1'b0}}, size_cur});

  assign cell_total = {{(CellBits-2*DimBits){1'b0}}, part_q}
                    * {{(CellBits+1-SizeW){1'b0}}, size_eff[2]};
  assign read_ok    = {1'b0, rd_idx_q} < cell_total;

  // counts stick at full scale
  assign count_inc = (rdata_q == '1) ? rdata_q : rdata_q + 1'b1;

  // ---------------------------------------------------------------------------
  // configuration writes
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_x_q  <= '0;
      org_y_q  <= '0;
      org_z_q  <= '0;
      inv_q    <= FixW'(65536);
      size_x_q <= SizeW'(DimLimit);
      size_y_q <= SizeW'(DimLimit);
      size_z_q <= SizeW'(DimLimit);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_ORIGIN_X: org_x_q  <= cfg_data_i[FixW-1:0];
        CFG_ORIGIN_Y: org_y_q  <= cfg_data_i[FixW-1:0];
        CFG_ORIGIN_Z: org_z_q  <= cfg_data_i[FixW-1:0];
        CFG_INV_CELL: inv_q    <= cfg_data_i[FixW-1:0];
        CFG_SIZE_X:   size_x_q <= cfg_data_i[SizeW-1:0];
        CFG_SIZE_Y:   size_y_q <= cfg_data_i[SizeW-1:0];
        CFG_SIZE_Z:   size_z_q <= cfg_data_i[SizeW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (item_fire) begin
          unique case (action_e'(item_i.action))
            ACT_ADD:   state_d = ST_MUL;
            ACT_READ:  state_d = ST_RD1;
            ACT_CLEAR: state_d = ST_CLEAR;
            ACT_NOP:   state_d = ST_REPLY;
          endcase
        end
      end
      ST_MUL:  state_d = ST_CHK;
      ST_CHK: begin
        if (!axis_hit) begin
          state_d = ST_REPLY;
        end else if (axis_q == AxisLast) begin
          state_d = ST_LIN1;
        end else begin
          state_d = ST_MUL;
        end
      end
      ST_LIN1:  state_d = ST_LIN2;
      ST_LIN2:  state_d = ST_FETCH;
      ST_RD1:   state_d = ST_RD2;
      ST_RD2:   state_d = read_ok ? ST_FETCH : ST_REPLY;
      ST_FETCH: state_d = ST_UPDATE;
      ST_UPDATE, ST_REPLY: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_CLEAR: begin
        if (clr_cnt_q == ClrLast) begin
          state_d = reply_q ? ST_REPLY : ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // sequencer: datapath and result
  // ---------------------------------------------------------------------------
  always_comb begin
    axis_d      = axis_q;
    is_add_d    = is_add_q;
    reply_d     = reply_q;
    diff_d      = diff_q;
    rd_idx_d    = rd_idx_q;
    prod_d      = prod_q;
    cell_d      = cell_q;
    part_d      = part_q;
    addr_d      = addr_q;
    clr_cnt_d   = clr_cnt_q;
    out_valid_d = out_valid_q && !result_o.ready;
    out_count_d = out_count_q;
    out_hit_d   = out_hit_q;
    out_idx_d   = out_idx_q;
    mem_we      = 1'b0;
    mem_waddr   = addr_q;
    mem_wdata   = count_inc;

    unique case (state_q)
      ST_IDLE: begin
        if (item_fire) begin
          // offsets are exact in 33 bits
          diff_d[0] = {item_i.pos_x[FixW-1], item_i.pos_x} - {org_x_q[FixW-1], org_x_q};
          diff_d[1] = {item_i.pos_y[FixW-1], item_i.pos_y} - {org_y_q[FixW-1], org_y_q};
          diff_d[2] = {item_i.pos_z[FixW-1], item_i.pos_z} - {org_z_q[FixW-1], org_z_q};
          rd_idx_d  = item_i.read_index;
          is_add_d  = (action_e'(item_i.action) == ACT_ADD);
          reply_d   = (action_e'(item_i.action) == ACT_CLEAR);
          axis_d    = '0;
          clr_cnt_d = '0;
        end
      end
      ST_MUL: begin
        prod_d = (2*FixW)'(mul_a) * (2*FixW)'(inv_q);
      end
      ST_CHK: begin
        if (axis_hit) begin
          cell_d[axis_q] = diff_cur[FixW] ? '0 : coord_hi[DimBits-1:0];
          // the axis counter stops on the last axis
          if (axis_q != AxisLast) begin
            axis_d = axis_q + 1'b1;
          end
        end
      end
      ST_LIN1: begin
        part_d = {{(SizeW){1'b0}}, cell_q[2]} * {{(DimBits){1'b0}}, size_eff[1]}
               + {{(SizeW){1'b0}}, cell_q[1]};
      end
      ST_LIN2: begin
        addr_d = {{(CellBits-2*DimBits-1){1'b0}}, part_q}
               * {{(CellBits-SizeW){1'b0}}, size_eff[0]}
               + {{(CellBits-DimBits){1'b0}}, cell_q[0]};
      end
      ST_RD1: begin
        part_d = {{(DimBits){1'b0}}, size_eff[0]} * {{(DimBits){1'b0}}, size_eff[1]};
      end
      ST_RD2: begin
        addr_d = rd_idx_q;
      end
      ST_FETCH: ;
      ST_UPDATE: begin
        if (out_free) begin
          mem_we      = is_add_q;
          out_valid_d = 1'b1;
          out_count_d = is_add_q ? count_inc : rdata_q;
          out_hit_d   = 1'b1;
          out_idx_d   = addr_q;
        end
      end
      ST_REPLY: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_count_d = '0;
          out_hit_d   = 1'b0;
          out_idx_d   = '0;
        end
      end
      ST_CLEAR: begin
        // one entry per cycle
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_q;
        mem_wdata = '0;
        clr_cnt_d = clr_cnt_q + 1'b1;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      axis_q      <= '0;
      is_add_q    <= 1'b0;
      reply_q     <= 1'b0;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      axis_q      <= axis_d;
      is_add_q    <= is_add_d;
      reply_q     <= reply_d;
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    diff_q      <= diff_d;
    rd_idx_q    <= rd_idx_d;
    prod_q      <= prod_d;
    cell_q      <= cell_d;
    part_q      <= part_d;
    addr_q      <= addr_d;
    out_count_q <= out_count_d;
    out_hit_q   <= out_hit_d;
    out_idx_q   <= out_idx_d;
  end

  // count store, read address follows the working cell
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[addr_q];
  end

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  `PVDH_ASSERT(a_accept_drops_ready, clk_i, rst_ni, item_fire |=> !item_i.ready, "ready after accept")
  `PVDH_ASSERT_NEVER(a_miss_is_zero, clk_i, rst_ni, out_valid_q && !out_hit_q && ((out_count_q != '0) || (out_idx_q != '0)), "miss beat not zero")
  `PVDH_ASSERT_NEVER(a_axis_range, clk_i, rst_ni, axis_q == 2'd3, "axis counter out of range")
  `PVDH_ASSERT(a_clear_walk, clk_i, rst_ni, ((state_q == ST_CLEAR) && (clr_cnt_q != ClrLast)) |=> ((state_q == ST_CLEAR) && (clr_cnt_q == $past(clr_cnt_q) + 1'b1)), "clear sweep broken")

endmodule

// ----- test/tb_particle_voxel_density_histogram_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_particle_voxel_density_histogram_core
// bins fixed point particles through the core under a series of grid set-ups
// and checks each result beat against a local voxel count predictor
// ----------------------------------------------------------------------------
module tb_particle_voxel_density_histogram_core;
  import pvdh_pkg::*;

  // one request as the core sees it
  typedef struct packed {
    action_e             act;
    logic [FixW-1:0]     px;
    logic [FixW-1:0]     py;
    logic [FixW-1:0]     pz;
    logic [CellBits-1:0] ridx;
  } bin_req_t;

  // one result beat as the predictor works it out
  typedef struct packed {
    logic [CountW-1:0]   count;
    logic                hit;
    logic [CellBits-1:0] idx;
  } bin_res_t;

  // settle time after the last beat before the grid is reprogrammed
  localparam int unsigned SettleCycles = 16;
  // receiver blackout, long enough to back the core up onto its input
  localparam int unsigned LongHold     = 600;

  // clock and reset
  logic clk_i = 1'b0;
  logic rst_ni;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // register write port
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  pvdh_item_if   item_if ();
  pvdh_result_if result_if ();

  particle_voxel_density_histogram_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .item_i     (item_if),
    .result_o   (result_if)
  );

  // ---------------------------------------------------------------------------
  // predictor state: our own copy of the grid registers and the count store
  // ---------------------------------------------------------------------------
  logic [FixW-1:0]   grid_org_x, grid_org_y, grid_org_z;
  logic [FixW-1:0]   grid_inv;
  logic [SizeW-1:0]  grid_size_x, grid_size_y, grid_size_z;
  logic [CountW-1:0] voxel_counts [CellTotal];

  bin_req_t request_q [$];         // requests still to be offered
  bin_res_t predicted_bins_q [$];  // results owed by the core, oldest first

  int unsigned queued_cnt   = 0;
  int unsigned accepted_cnt = 0;
  int unsigned beat_cnt     = 0;
  int unsigned fail_cnt     = 0;

  // idling control, switched per phase
  bit   sender_gaps   = 1'b1;
  bit   receiver_gaps = 1'b1;
  logic long_hold     = 1'b0;

  // stimulus memory for repeats and reads of live cells
  logic [FixW-1:0]     last_px, last_py, last_pz;
  bit                  have_last = 1'b0;
  logic [CellBits-1:0] last_lin  = '0;
  int unsigned         clears_left = 5;

  // sizes above the dimension limit behave as the limit
  function automatic int unsigned grid_dim(input logic [SizeW-1:0] s);
    return (s > DimLimit) ? DimLimit : s;
  endfunction

  // cell along one axis: floor of (pos - origin) * inverse cell size, exact
  function automatic bit axis_cell(input logic [FixW-1:0] pos, input logic [FixW-1:0] org,
                                   input int unsigned n, output int unsigned cell_no);
    logic signed [FixW:0] diff;
    logic [2*FixW:0]      prod;
    cell_no = 0;
    diff = $signed({pos[FixW-1], pos}) - $signed({org[FixW-1], org});
    // below the corner only survives when the scale wipes the offset out
    if (diff < 0)
      return (grid_inv == '0) && (n > 0);
    prod = {32'b0, diff} * {33'b0, grid_inv};
    if (prod[2*FixW:FixW] >= n)
      return 1'b0;
    cell_no = prod[FixW+DimBits-1:FixW];
    return 1'b1;
  endfunction

  // predicted result of one accepted request, updating the count store
  function automatic bin_res_t bin_particle(input bin_req_t req);
    bin_res_t    res;
    int unsigned nx, ny, nz, cx, cy, cz, lin;
    res = '0;
    nx  = grid_dim(grid_size_x);
    ny  = grid_dim(grid_size_y);
    nz  = grid_dim(grid_size_z);
    case (req.act)
      ACT_ADD: begin
        if (axis_cell(req.px, grid_org_x, nx, cx) && axis_cell(req.py, grid_org_y, ny, cy) &&
            axis_cell(req.pz, grid_org_z, nz, cz)) begin
          lin = (cz * ny + cy) * nx + cx;
          // counts stick at all ones
          if (voxel_counts[lin] != '1)
            voxel_counts[lin] = voxel_counts[lin] + 1'b1;
          res.count = voxel_counts[lin];
          res.hit   = 1'b1;
          res.idx   = lin[CellBits-1:0];
        end
      end
      ACT_READ: begin
        if (req.ridx < nx * ny * nz) begin
          res.count = voxel_counts[req.ridx];
          res.hit   = 1'b1;
          res.idx   = req.ridx;
        end
      end
      ACT_CLEAR: begin
        foreach (voxel_counts[i])
          voxel_counts[i] = '0;
      end
      default: ;
    endcase
    return res;
  endfunction

  // idle length: mostly none or short, now and then a long one
  function automatic int unsigned draw_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60)
      return 0;
    if (r < 85)
      return $urandom_range(1, 3);
    if (r < 97)
      return $urandom_range(4, 12);
    return $urandom_range(25, 80);
  endfunction

  // position aimed at a chosen cell of one axis, with some deliberate strays
  function automatic logic [FixW-1:0] aim_axis(input logic [FixW-1:0] org,
                                               input int unsigned n,
                                               output int unsigned cell_no);
    logic [63:0] span;
    int unsigned r;
    r       = $urandom_range(0, 99);
    cell_no = (n == 0) ? 0 : $urandom_range(0, n - 1);
    if (r < 8)
      return $urandom();                        // anywhere at all
    if (r < 14)
      return org - $urandom_range(1, 1 << 16);  // just under the corner
    if (r < 20)
      cell_no = n;                              // just past the far face
    else if (r < 40)
      cell_no = (n < 2) ? 0 : $urandom_range(0, 1);  // hot corner, many repeats
    if (grid_inv == '0)
      return org + $urandom();
    span = ((64'(cell_no) << 32) | 64'($urandom())) / 64'(grid_inv);
    return org + span[FixW-1:0];
  endfunction

  task automatic queue_item(input action_e act, input logic [FixW-1:0] px, py, pz,
                            input logic [CellBits-1:0] ridx);
    request_q.push_back('{act: act, px: px, py: py, pz: pz, ridx: ridx});
    queued_cnt++;
  endtask

  // random stream shaped by the current grid: mostly aimed adds and live reads
  task automatic queue_random(input int unsigned n_items);
    int unsigned r, total, cx, cy, cz;
    action_e     act;
    logic [FixW-1:0]     px, py, pz;
    logic [CellBits-1:0] ridx;
    total = grid_dim(grid_size_x) * grid_dim(grid_size_y) * grid_dim(grid_size_z);
    repeat (n_items) begin
      r    = $urandom_range(0, 999);
      px   = $urandom();
      py   = $urandom();
      pz   = $urandom();
      ridx = $urandom();
      if (r < 5 && clears_left > 0) begin
        act = ACT_CLEAR;
        clears_left--;
      end else if (r < 760) begin
        act = ACT_ADD;
        if (have_last && $urandom_range(0, 4) == 0) begin
          // same particle again, often straight behind the previous one
          px = last_px;
          py = last_py;
          pz = last_pz;
        end else begin
          px = aim_axis(grid_org_x, grid_dim(grid_size_x), cx);
          py = aim_axis(grid_org_y, grid_dim(grid_size_y), cy);
          pz = aim_axis(grid_org_z, grid_dim(grid_size_z), cz);
          if (cx < grid_dim(grid_size_x) && cy < grid_dim(grid_size_y) &&
              cz < grid_dim(grid_size_z))
            last_lin = (cz * grid_dim(grid_size_y) + cy) * grid_dim(grid_size_x) + cx;
        end
        last_px   = px;
        last_py   = py;
        last_pz   = pz;
        have_last = 1'b1;
      end else if (r < 940) begin
        act = ACT_READ;
        case ($urandom_range(0, 3))
          0, 1:    ridx = (total == 0) ? '0 : $urandom_range(0, total - 1);
          2:       ridx = last_lin;
          default: ;  // full index range, often beyond the grid
        endcase
      end else begin
        act = ACT_NOP;
      end
      queue_item(act, px, py, pz, ridx);
    end
  endtask

  // one register write, mirrored into the predictor's copy
  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      CFG_ORIGIN_X: grid_org_x  = data;
      CFG_ORIGIN_Y: grid_org_y  = data;
      CFG_ORIGIN_Z: grid_org_z  = data;
      CFG_INV_CELL: grid_inv    = data;
      CFG_SIZE_X:   grid_size_x = data[SizeW-1:0];
      CFG_SIZE_Y:   grid_size_y = data[SizeW-1:0];
      CFG_SIZE_Z:   grid_size_z = data[SizeW-1:0];
      default: ;
    endcase
  endtask

  // whole grid set-up; size writes carry junk above the 6 bit field
  task automatic set_grid(input logic [FixW-1:0] ox, oy, oz, inv,
                          input logic [SizeW-1:0] sx, sy, sz);
    write_reg(CFG_ORIGIN_X, ox);
    write_reg(CFG_ORIGIN_Y, oy);
    write_reg(CFG_ORIGIN_Z, oz);
    write_reg(CFG_INV_CELL, inv);
    write_reg(CFG_SIZE_X, {26'($urandom()), sx});
    write_reg(CFG_SIZE_Y, {26'($urandom()), sy});
    write_reg(CFG_SIZE_Z, {26'($urandom()), sz});
  endtask

  // hold the sender until every owed beat is back, then let the core settle
  task automatic drain();
    while (!(accepted_cnt == queued_cnt && predicted_bins_q.size() == 0))
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // request driver: offers queued requests, random gaps after each beat
  // ---------------------------------------------------------------------------
  bin_req_t    held;
  int unsigned gap_left = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (item_if.valid && item_if.ready) begin
        predicted_bins_q.push_back(bin_particle(held));
        accepted_cnt++;
      end
      // a stalled beat stays on the wires untouched
      if (!item_if.valid || item_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          item_if.valid <= 1'b0;
        end else if (request_q.size() > 0) begin
          held                = request_q.pop_front();
          item_if.valid      <= 1'b1;
          item_if.action     <= held.act;
          item_if.pos_x      <= held.px;
          item_if.pos_y      <= held.py;
          item_if.pos_z      <= held.pz;
          item_if.read_index <= held.ridx;
          gap_left            = sender_gaps ? draw_gap() : 0;
        end else begin
          item_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor: field by field against the oldest owed beat
  // ---------------------------------------------------------------------------
  bin_res_t    want;
  int unsigned rx_stall = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_if.valid && result_if.ready) begin
        beat_cnt++;
        if (predicted_bins_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("beat %0d: result with nothing owed (count %h hit %0d index %0d)",
                     beat_cnt, result_if.cell_count, result_if.hit, result_if.cell_index);
        end else begin
          want = predicted_bins_q.pop_front();
          if (result_if.cell_count !== want.count || result_if.hit !== want.hit ||
              result_if.cell_index !== want.idx) begin
            fail_cnt++;
            if (fail_cnt <= 10)
              $display("beat %0d: count %h/%h hit %0d/%0d index %0d/%0d (exp/got)",
                       beat_cnt, want.count, result_if.cell_count, want.hit,
                       result_if.hit, want.idx, result_if.cell_index);
          end
        end
      end
      if (long_hold) begin
        result_if.ready <= 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= 1'b1;
        if (receiver_gaps)
          rx_stall = draw_gap();
      end
    end
  end

  // long receiver blackout once the stream is under way; the sender keeps
  // offering so the core backs up and drops its input ready
  initial begin
    while (accepted_cnt < 60) @(posedge clk_i);
    long_hold <= 1'b1;
    repeat (LongHold) @(posedge clk_i);
    long_hold <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // phases: grid set-up, then directed and random requests
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = CFG_ORIGIN_X;
    cfg_data_i         = '0;
    item_if.valid      = 1'b0;
    item_if.action     = ACT_NOP;
    item_if.pos_x      = '0;
    item_if.pos_y      = '0;
    item_if.pos_z      = '0;
    item_if.read_index = '0;
    result_if.ready    = 1'b0;
    // register defaults and an empty store, as after reset
    grid_org_x  = '0;
    grid_org_y  = '0;
    grid_org_z  = '0;
    grid_inv    = 32'h0001_0000;
    grid_size_x = 6'd32;
    grid_size_y = 6'd32;
    grid_size_z = 6'd32;
    foreach (voxel_counts[i])
      voxel_counts[i] = '0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // unit cells from the origin over the full 32 cube; written while the
    // store sweep after reset is still running
    set_grid('0, '0, '0, 32'h0001_0000, 6'd32, 6'd32, 6'd32);
    queue_item(ACT_ADD, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, '0);
    // same cell straight away, must see the first increment
    queue_item(ACT_ADD, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, '1);
    // fraction just short of one still lands in cell 0
    queue_item(ACT_ADD, 32'h0000_FFFF, 32'h0000_FFFF, 32'h0000_FFFF, '0);
    // far corner of the grid
    queue_item(ACT_ADD, 32'h001F_FFFF, 32'h001F_FFFF, 32'h001F_FFFF, '0);
    queue_item(ACT_ADD, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, '0);
    // one past the far face on each axis
    queue_item(ACT_ADD, 32'h0020_0000, 32'h0000_0000, 32'h0000_0000, '0);
    queue_item(ACT_ADD, 32'h0000_0000, 32'h0020_0000, 32'h0000_0000, '0);
    queue_item(ACT_ADD, 32'h0000_0000, 32'h0000_0000, 32'h0020_0000, '0);
    // one lsb below the corner
    queue_item(ACT_ADD, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, '0);
    // position extremes
    queue_item(ACT_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '0);
    queue_item(ACT_ADD, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, '0);
    queue_item(ACT_READ, $urandom(), $urandom(), $urandom(), 15'd0);
    queue_item(ACT_READ, $urandom(), $urandom(), $urandom(), 15'd32767);
    queue_item(ACT_READ, $urandom(), $urandom(), $urandom(), 15'd3137);
    queue_item(ACT_READ, $urandom(), $urandom(), $urandom(), 15'd100);
    // unused action code, nothing may move
    queue_item(ACT_NOP, $urandom(), $urandom(), $urandom(), $urandom());
    queue_item(ACT_READ, '0, '0, '0, 15'd0);
    // clear, then the store must read back empty
    queue_item(ACT_CLEAR, $urandom(), $urandom(), $urandom(), $urandom());
    queue_item(ACT_READ, '1, '1, '1, 15'd0);
    queue_item(ACT_ADD, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, '0);
    queue_item(ACT_READ, '0, '0, '0, 15'd0);
    // a saturated count needs 2^32 adds to one cell, out of reach here
    queue_random(150);
    drain();

    // half size cells on a lopsided grid, no idling on either side
    sender_gaps   = 1'b0;
    receiver_gaps = 1'b0;
    set_grid(32'hFFFE_8000, 32'h0003_0000, 32'h0000_4000, 32'h0002_0000, 6'd8, 6'd4, 6'd16);
    // reads at and around the edge of the 512 cell volume
    queue_item(ACT_READ, '0, '0, '0, 15'd511);
    queue_item(ACT_READ, '0, '0, '0, 15'd512);
    queue_item(ACT_READ, '0, '0, '0, 15'd32767);
    queue_random(80);
    drain();

    // zero scale: every particle, wherever it is, falls into cell 0
    sender_gaps   = 1'b1;
    receiver_gaps = 1'b1;
    set_grid(32'h8000_0000, 32'h7FFF_FFFF, '0, '0, 6'd1, 6'd1, 6'd1);
    queue_random(30);
    drain();

    // a zero size: every add misses, every read is out of range
    set_grid($urandom(), $urandom(), $urandom(), 32'h0001_0000, 6'd0, 6'd5, 6'd63);
    queue_random(20);
    drain();

    // finest cells at the origin extremes; sizes above the limit saturate
    set_grid(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0100, 32'hFFFF_FFFF,
             6'd32, 6'd63, 6'd2);
    queue_random(60);
    drain();

    // coarsest cells, back to back again
    sender_gaps   = 1'b0;
    receiver_gaps = 1'b0;
    set_grid(32'hFFFF_0000, 32'h0000_0001, 32'h1234_5678, 32'h0000_0001,
             6'd3, 6'd7, 6'd1);
    queue_random(40);
    drain();

    // random grids of moderate reach
    sender_gaps   = 1'b1;
    receiver_gaps = 1'b1;
    repeat (3) begin
      set_grid(32'($signed(30'($urandom()))), 32'($signed(30'($urandom()))),
               32'($signed(30'($urandom()))), $urandom_range(32'h4000, 32'h8_0000),
               $urandom_range(1, 32), $urandom_range(1, 32), $urandom_range(1, 32));
      queue_random(50);
      drain();
    end

    if (fail_cnt == 0 && predicted_bins_q.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  // watchdog, several times the slowest correct run (store sweeps dominate)
  initial begin
    #(10_000_000);
    $display("Test completed with failures");
    $finish;
  end

endmodule
